// File: hdl/bdb_pkg.sv
// ----------------------------------------------------------------------------
// bdb_pkg
// Shared types and constants of the B-spline De Boor evaluator.
// ----------------------------------------------------------------------------
package bdb_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CTRL_DEPTH = 64;
  localparam int unsigned DEG_MAX    = 7;
  localparam int unsigned KNOT_DEPTH = CTRL_DEPTH + DEG_MAX + 1;
  localparam int unsigned CTRL_AW    = 6;
  localparam int unsigned KNOT_AW    = 7;
  localparam int unsigned WORK_AW    = 3;
  localparam int unsigned CNT_W      = 7;

  localparam int unsigned OPA_W   = COORD_W + 1;
  localparam int unsigned OPB_W   = OPA_W + FRAC_W;
  localparam int unsigned CHUNK_W = 25;
  localparam int unsigned PROD_W  = OPA_W + OPB_W;

  typedef enum logic [1:0] {
    MODE_CTRL = 2'd0,
    MODE_KNOT = 2'd1,
    MODE_EVAL = 2'd2,
    MODE_TESS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_DEGREE  = 2'd0,
    CFG_CONTROL = 2'd1,
    CFG_KNOTS   = 2'd2,
    CFG_SAMPLES = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    AR_OP_DIV = 1'b0,
    AR_OP_MUL = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } arith_rsp_t;

endpackage

// File: hdl/bdb_arith.sv
// ----------------------------------------------------------------------------
// bdb_arith
// Shared arithmetic unit: radix-2 restoring divider and a multiplier that
// builds the product from two partial products.
// ----------------------------------------------------------------------------
module bdb_arith (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bdb_pkg::arith_req_t             req_i,
  input  logic [bdb_pkg::OPA_W-1:0]       opa_i,
  input  logic [bdb_pkg::OPB_W-1:0]       opb_i,
  output bdb_pkg::arith_rsp_t             rsp_o,
  output logic [bdb_pkg::PROD_W-1:0]      res_o
);

  localparam int unsigned PP_W = bdb_pkg::OPA_W + bdb_pkg::CHUNK_W;
  localparam int unsigned HI_W = bdb_pkg::OPB_W - bdb_pkg::CHUNK_W;

  typedef enum logic [2:0] {
    AR_IDLE = 3'b001,
    AR_DIV  = 3'b010,
    AR_MUL  = 3'b100
  } ar_state_e;

  ar_state_e                     state_q;
  logic [5:0]                    cnt_q;
  logic                          done_q;
  bdb_pkg::arith_op_e            op_q;
  logic [bdb_pkg::OPA_W-1:0]     opa_q;
  logic [bdb_pkg::OPB_W-1:0]     opb_q;
  logic [bdb_pkg::OPB_W-1:0]     dvd_q;
  logic [bdb_pkg::OPA_W-1:0]     rem_q;
  logic [PP_W-1:0]               prod_q;
  logic [bdb_pkg::PROD_W-1:0]    acc_q;

  logic [bdb_pkg::OPA_W:0]       rem_s;
  logic                          ge;
  logic [bdb_pkg::OPA_W:0]       rem_sub;
  logic [bdb_pkg::CHUNK_W-1:0]   chunk;
  logic [PP_W-1:0]               pp;

  assign rem_s   = {rem_q, dvd_q[bdb_pkg::OPB_W-1]};
  assign ge      = rem_s >= {1'b0, opa_q};
  assign rem_sub = rem_s - {1'b0, opa_q};
  assign chunk   = (cnt_q == 6'd0) ? opb_q[bdb_pkg::CHUNK_W-1:0]
                                   : {1'b0, opb_q[bdb_pkg::OPB_W-1:bdb_pkg::CHUNK_W]};
  assign pp      = opa_q * chunk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        AR_IDLE: begin
          if (req_i.start) begin
            if (req_i.op == bdb_pkg::AR_OP_DIV) begin
              cnt_q   <= 6'(bdb_pkg::OPB_W - 1);
              state_q <= AR_DIV;
            end else begin
              cnt_q   <= 6'd0;
              state_q <= AR_MUL;
            end
          end
        end
        AR_DIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            state_q <= AR_IDLE;
            done_q  <= 1'b1;
          end
        end
        AR_MUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd2) begin
            state_q <= AR_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= AR_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == AR_IDLE && req_i.start) begin
      op_q  <= req_i.op;
      opa_q <= opa_i;
      opb_q <= opb_i;
      dvd_q <= opb_i;
      rem_q <= '0;
    end else if (state_q == AR_DIV) begin
      rem_q <= ge ? rem_sub[bdb_pkg::OPA_W-1:0] : rem_s[bdb_pkg::OPA_W-1:0];
      dvd_q <= {dvd_q[bdb_pkg::OPB_W-2:0], ge};
    end else if (state_q == AR_MUL) begin
      prod_q <= pp;
      if (cnt_q == 6'd1) begin
        acc_q <= {{(bdb_pkg::PROD_W-PP_W){1'b0}}, prod_q};
      end else if (cnt_q == 6'd2) begin
        acc_q <= acc_q + ({{(bdb_pkg::PROD_W-PP_W){1'b0}}, prod_q} << bdb_pkg::CHUNK_W);
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = (state_q != AR_IDLE);
  assign res_o      = (op_q == bdb_pkg::AR_OP_DIV)
                      ? {{(bdb_pkg::PROD_W-bdb_pkg::OPB_W){1'b0}}, dvd_q} : acc_q;

endmodule

// File: hdl/bspline_de_boor_evaluator_top.sv
// ----------------------------------------------------------------------------
// bspline_de_boor_evaluator_top
// B-spline point evaluation and tessellation by De Boor's algorithm over
// loaded control point and knot stores, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        in_valid/ready, mode, slot, coord, param  to block
//  out       out_valid/ready, point_x/y, last_point    from block
//  cfg       cfg_valid/ready, cfg_index, cfg_data      to block
//
//  Each curve point takes a span search by bisection, a load per work
//  entry and, per blend, a divide (when the knot interval is positive) and
//  two multiplies on the one shared arithmetic unit. No clearing pass
//  after reset. A stalled output holds the sequencer in its emit step;
//  in_ready is high only between transactions.
// ----------------------------------------------------------------------------
module bspline_de_boor_evaluator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [6:0]         slot_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] param_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic               last_point_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);

  localparam int unsigned CW = bdb_pkg::COORD_W;
  localparam int unsigned AW = bdb_pkg::OPA_W;
  localparam int unsigned BW = bdb_pkg::OPB_W;
  localparam int unsigned PW = bdb_pkg::PROD_W;
  localparam int unsigned FW = bdb_pkg::FRAC_W;

  typedef enum logic [1:0] {
    CLS_EMPTY = 2'd0,
    CLS_DEGEN = 2'd1,
    CLS_CURVE = 2'd2
  } cls_e;

  typedef enum logic [28:0] {
    S_IDLE    = 29'h0000001,
    S_DEG_RD  = 29'h0000002,
    S_DEG_CAP = 29'h0000004,
    S_EMIT    = 29'h0000008,
    S_TS_K0   = 29'h0000010,
    S_TS_K1   = 29'h0000020,
    S_TS_K2   = 29'h0000040,
    S_TS_MUL  = 29'h0000080,
    S_TS_MULW = 29'h0000100,
    S_TS_DIVW = 29'h0000200,
    S_SP_K0   = 29'h0000400,
    S_SP_K1   = 29'h0000800,
    S_SP_K2   = 29'h0001000,
    S_BS_ADDR = 29'h0002000,
    S_BS_CMP  = 29'h0004000,
    S_LD_ADDR = 29'h0008000,
    S_LD_WR   = 29'h0010000,
    S_BL_K0   = 29'h0020000,
    S_BL_K1   = 29'h0040000,
    S_BL_K2   = 29'h0080000,
    S_BL_DIVW = 29'h0100000,
    S_BL_W0   = 29'h0200000,
    S_BL_W1   = 29'h0400000,
    S_BL_W2   = 29'h0800000,
    S_BL_MXW  = 29'h1000000,
    S_BL_MYW  = 29'h2000000,
    S_BL_WR   = 29'h4000000,
    S_EV_RD   = 29'h8000000,
    S_EV_CAP  = 29'h10000000
  } state_e;

  function automatic logic signed [CW-1:0] blend_sat(input logic signed [CW-1:0] prev,
                                                     input logic neg,
                                                     input logic [PW-1:0] prod);
    logic              over;
    logic [AW-1:0]     tm;
    logic signed [CW+2:0] sum;
    over = |prod[PW-1:AW+FW];
    tm   = prod[AW+FW-1:FW];
    sum  = neg ? ({{3{prev[CW-1]}}, prev} - {2'b00, tm})
               : ({{3{prev[CW-1]}}, prev} + {2'b00, tm});
    if (over) begin
      blend_sat = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else if (sum > $signed({4'b0000, {(CW-1){1'b1}}})) begin
      blend_sat = {1'b0, {(CW-1){1'b1}}};
    end else if (sum < $signed({4'b1111, {(CW-1){1'b0}}})) begin
      blend_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      blend_sat = sum[CW-1:0];
    end
  endfunction

  state_e state_q, state_d;

  logic [2:0] deg_q;
  logic [6:0] cc_q, kc_q, sc_q;

  logic [6:0] i_q, lo_q, hi_q;
  logic [2:0] j_q, r_q;
  logic [1:0] mode_q;
  logic       deg_path_q;

  logic signed [CW-1:0] t_q, start_q, end_q, lower_q;
  logic [BW-1:0]        alpha_mag_q;
  logic                 alpha_neg_q;
  logic signed [CW-1:0] prev_x_q, prev_y_q, new_x_q;
  logic [AW-1:0]        dmy_q;
  logic                 negx_q, negy_q;
  logic signed [CW-1:0] res_x_q, res_y_q;
  logic                 res_last_q;

  logic                 out_valid_q;
  logic signed [CW-1:0] out_x_q, out_y_q;
  logic                 out_last_q;

  logic signed [CW-1:0] ctrl_x_mem [bdb_pkg::CTRL_DEPTH];
  logic signed [CW-1:0] ctrl_y_mem [bdb_pkg::CTRL_DEPTH];
  logic signed [CW-1:0] knot_mem   [bdb_pkg::KNOT_DEPTH];
  logic signed [CW-1:0] work_x_mem [bdb_pkg::DEG_MAX+1];
  logic signed [CW-1:0] work_y_mem [bdb_pkg::DEG_MAX+1];

  logic signed [CW-1:0] ctrl_rd_x_q, ctrl_rd_y_q, knot_rd_q, work_rd_x_q, work_rd_y_q;
  logic [bdb_pkg::CTRL_AW-1:0] ctrl_raddr;
  logic [bdb_pkg::KNOT_AW-1:0] knot_raddr;
  logic [bdb_pkg::WORK_AW-1:0] work_raddr, work_waddr;
  logic                        work_we;
  logic signed [CW-1:0]        work_wx, work_wy;

  bdb_pkg::arith_req_t ar_req;
  bdb_pkg::arith_rsp_t ar_rsp;
  logic [AW-1:0]       ar_opa;
  logic [BW-1:0]       ar_opb;
  logic [PW-1:0]       ar_res;

  logic       in_acc;
  logic       emit_go;
  cls_e       cls;
  logic [7:0] knot_need;
  logic [7:0] mid_sum;
  logic [6:0] mid;
  logic [6:0] lo_idx, up_idx;
  logic [6:0] sc_m1;

  logic signed [AW-1:0] de_s, w_s, n_s, dx_s, dy_s;
  logic [AW-1:0]        de_mag, nm, dmx, dmy;
  logic                 w_pos;
  logic signed [AW:0]   t_sum;
  logic [AW-1:0]        tq;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign emit_go     = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  assign knot_need = {1'b0, cc_q} + {5'b0, deg_q} + 8'd1;
  always_comb begin
    if (cc_q == 7'd0) begin
      cls = CLS_EMPTY;
    end else if (deg_q == 3'd0 || cc_q <= {4'b0, deg_q} || {1'b0, kc_q} < knot_need) begin
      cls = CLS_DEGEN;
    end else begin
      cls = CLS_CURVE;
    end
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[7:1];
  assign lo_idx  = {4'b0, j_q} + lo_q - {4'b0, deg_q};
  assign up_idx  = {4'b0, j_q} + 7'd1 + lo_q - {4'b0, r_q};
  assign sc_m1   = sc_q - 7'd1;

  assign de_s   = {end_q[CW-1], end_q} - {start_q[CW-1], start_q};
  assign de_mag = de_s[AW-1] ? (~de_s + 1'b1) : de_s;
  assign w_s    = {knot_rd_q[CW-1], knot_rd_q} - {lower_q[CW-1], lower_q};
  assign w_pos  = !w_s[AW-1] && (w_s != '0);
  assign n_s    = {t_q[CW-1], t_q} - {lower_q[CW-1], lower_q};
  assign nm     = n_s[AW-1] ? (~n_s + 1'b1) : n_s;
  assign dx_s   = {work_rd_x_q[CW-1], work_rd_x_q} - {prev_x_q[CW-1], prev_x_q};
  assign dmx    = dx_s[AW-1] ? (~dx_s + 1'b1) : dx_s;
  assign dy_s   = {work_rd_y_q[CW-1], work_rd_y_q} - {prev_y_q[CW-1], prev_y_q};
  assign dmy    = dy_s[AW-1] ? (~dy_s + 1'b1) : dy_s;
  assign tq     = ar_res[AW-1:0];
  assign t_sum  = de_s[AW-1] ? ({start_q[CW-1], start_q[CW-1], start_q} - {1'b0, tq})
                             : ({start_q[CW-1], start_q[CW-1], start_q} + {1'b0, tq});

  always_comb begin
    ar_req.start = 1'b0;
    ar_req.op    = bdb_pkg::AR_OP_DIV;
    ar_opa       = '0;
    ar_opb       = '0;
    unique case (state_q)
      S_TS_MUL: begin
        ar_req.start = 1'b1;
        ar_req.op    = bdb_pkg::AR_OP_MUL;
        ar_opa       = de_mag;
        ar_opb       = {{(BW-7){1'b0}}, i_q};
      end
      S_TS_MULW: begin
        ar_req.start = ar_rsp.done;
        ar_opa       = {{(AW-7){1'b0}}, sc_m1};
        ar_opb       = ar_res[BW-1:0];
      end
      S_BL_K2: begin
        ar_req.start = w_pos;
        ar_opa       = w_s;
        ar_opb       = {nm, {FW{1'b0}}};
      end
      S_BL_W2: begin
        ar_req.start = 1'b1;
        ar_req.op    = bdb_pkg::AR_OP_MUL;
        ar_opa       = dmx;
        ar_opb       = alpha_mag_q;
      end
      S_BL_MXW: begin
        ar_req.start = ar_rsp.done;
        ar_req.op    = bdb_pkg::AR_OP_MUL;
        ar_opa       = dmy_q;
        ar_opb       = alpha_mag_q;
      end
      default: ar_req.start = 1'b0;
    endcase
  end

  bdb_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ar_req),
    .opa_i  (ar_opa),
    .opb_i  (ar_opb),
    .rsp_o  (ar_rsp),
    .res_o  (ar_res)
  );

  always_comb begin
    knot_raddr = '0;
    unique case (state_q)
      S_TS_K0, S_SP_K0: knot_raddr = {4'b0, deg_q};
      S_TS_K1, S_SP_K1: knot_raddr = cc_q;
      S_BS_ADDR:        knot_raddr = mid;
      S_BL_K0:          knot_raddr = lo_idx;
      S_BL_K1:          knot_raddr = up_idx;
      default:          knot_raddr = '0;
    endcase
  end

  assign ctrl_raddr = (state_q == S_DEG_RD) ? i_q[bdb_pkg::CTRL_AW-1:0]
                                            : lo_idx[bdb_pkg::CTRL_AW-1:0];

  always_comb begin
    unique case (state_q)
      S_BL_W0: work_raddr = j_q - 3'd1;
      S_EV_RD: work_raddr = deg_q;
      default: work_raddr = j_q;
    endcase
  end

  assign work_we    = (state_q == S_LD_WR) || (state_q == S_BL_WR);
  assign work_waddr = j_q;
  assign work_wx    = (state_q == S_LD_WR) ? ctrl_rd_x_q : new_x_q;
  assign work_wy    = (state_q == S_LD_WR) ? ctrl_rd_y_q
                                           : blend_sat(prev_y_q, negy_q, ar_res);

  always_ff @(posedge clk_i) begin
    if (in_acc && mode_i == bdb_pkg::MODE_CTRL && !slot_i[6]) begin
      ctrl_x_mem[slot_i[bdb_pkg::CTRL_AW-1:0]] <= coord_x_i;
      ctrl_y_mem[slot_i[bdb_pkg::CTRL_AW-1:0]] <= coord_y_i;
    end
    ctrl_rd_x_q <= ctrl_x_mem[ctrl_raddr];
    ctrl_rd_y_q <= ctrl_y_mem[ctrl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && mode_i == bdb_pkg::MODE_KNOT && slot_i < 7'(bdb_pkg::KNOT_DEPTH)) begin
      knot_mem[slot_i] <= param_value_i;
    end
    knot_rd_q <= knot_mem[knot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) begin
      work_x_mem[work_waddr] <= work_wx;
      work_y_mem[work_waddr] <= work_wy;
    end
    work_rd_x_q <= work_x_mem[work_raddr];
    work_rd_y_q <= work_y_mem[work_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && mode_i == bdb_pkg::MODE_EVAL) begin
          unique case (cls)
            CLS_EMPTY: state_d = S_EMIT;
            CLS_DEGEN: state_d = S_DEG_RD;
            default:   state_d = S_SP_K0;
          endcase
        end else if (in_acc && mode_i == bdb_pkg::MODE_TESS) begin
          unique case (cls)
            CLS_EMPTY: state_d = S_IDLE;
            CLS_DEGEN: state_d = S_DEG_RD;
            default:   state_d = S_TS_K0;
          endcase
        end
      end
      S_DEG_RD:  state_d = S_DEG_CAP;
      S_DEG_CAP: state_d = S_EMIT;
      S_EMIT: begin
        if (emit_go) begin
          if (res_last_q)      state_d = S_IDLE;
          else if (deg_path_q) state_d = S_DEG_RD;
          else                 state_d = S_TS_MUL;
        end
      end
      S_TS_K0:   state_d = S_TS_K1;
      S_TS_K1:   state_d = S_TS_K2;
      S_TS_K2:   state_d = S_TS_MUL;
      S_TS_MUL:  state_d = S_TS_MULW;
      S_TS_MULW: if (ar_rsp.done) state_d = S_TS_DIVW;
      S_TS_DIVW: if (ar_rsp.done) state_d = S_SP_K0;
      S_SP_K0:   state_d = S_SP_K1;
      S_SP_K1:   state_d = (t_q <= knot_rd_q) ? S_LD_ADDR : S_SP_K2;
      S_SP_K2:   state_d = (t_q >= knot_rd_q) ? S_LD_ADDR : S_BS_ADDR;
      S_BS_ADDR: state_d = ((hi_q - lo_q) > 7'd1) ? S_BS_CMP : S_LD_ADDR;
      S_BS_CMP:  state_d = S_BS_ADDR;
      S_LD_ADDR: state_d = S_LD_WR;
      S_LD_WR:   state_d = (j_q == deg_q) ? S_BL_K0 : S_LD_ADDR;
      S_BL_K0:   state_d = S_BL_K1;
      S_BL_K1:   state_d = S_BL_K2;
      S_BL_K2:   state_d = w_pos ? S_BL_DIVW : S_BL_W0;
      S_BL_DIVW: if (ar_rsp.done) state_d = S_BL_W0;
      S_BL_W0:   state_d = S_BL_W1;
      S_BL_W1:   state_d = S_BL_W2;
      S_BL_W2:   state_d = S_BL_MXW;
      S_BL_MXW:  if (ar_rsp.done) state_d = S_BL_MYW;
      S_BL_MYW:  if (ar_rsp.done) state_d = S_BL_WR;
      S_BL_WR: begin
        if (j_q == r_q && r_q == deg_q) state_d = S_EV_RD;
        else                            state_d = S_BL_K0;
      end
      S_EV_RD:   state_d = S_EV_CAP;
      S_EV_CAP:  state_d = S_EMIT;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      deg_q       <= 3'd3;
      cc_q        <= 7'd0;
      kc_q        <= 7'd0;
      sc_q        <= 7'd16;
      i_q         <= '0;
      j_q         <= '0;
      r_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mode_q      <= '0;
      deg_path_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (bdb_pkg::cfg_idx_e'(cfg_index_i))
          bdb_pkg::CFG_DEGREE:  deg_q <= cfg_data_i[2:0];
          bdb_pkg::CFG_CONTROL: cc_q  <= (cfg_data_i > 7'(bdb_pkg::CTRL_DEPTH))
                                         ? 7'(bdb_pkg::CTRL_DEPTH) : cfg_data_i;
          bdb_pkg::CFG_KNOTS:   kc_q  <= (cfg_data_i > 7'(bdb_pkg::KNOT_DEPTH))
                                         ? 7'(bdb_pkg::KNOT_DEPTH) : cfg_data_i;
          bdb_pkg::CFG_SAMPLES: begin
            if (cfg_data_i < 7'd2)                           sc_q <= 7'd2;
            else if (cfg_data_i > 7'(bdb_pkg::CTRL_DEPTH))   sc_q <= 7'(bdb_pkg::CTRL_DEPTH);
            else                                             sc_q <= cfg_data_i;
          end
          default: deg_q <= deg_q;
        endcase
      end

      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            mode_q     <= mode_i;
            i_q        <= '0;
            deg_path_q <= (cls == CLS_DEGEN);
          end
        end
        S_EMIT: if (emit_go && !res_last_q) i_q <= i_q + 7'd1;
        S_SP_K1: if (t_q <= knot_rd_q) begin
          lo_q <= {4'b0, deg_q};
          j_q  <= '0;
        end
        S_SP_K2: begin
          j_q <= '0;
          if (t_q >= knot_rd_q) begin
            lo_q <= cc_q - 7'd1;
          end else begin
            lo_q <= {4'b0, deg_q};
            hi_q <= cc_q;
          end
        end
        S_BS_ADDR: j_q <= '0;
        S_BS_CMP: begin
          if (t_q < knot_rd_q) hi_q <= mid;
          else                 lo_q <= mid;
        end
        S_LD_WR: begin
          if (j_q == deg_q) begin
            r_q <= 3'd1;
          end else begin
            j_q <= j_q + 3'd1;
          end
        end
        S_BL_WR: begin
          if (j_q == r_q) begin
            r_q <= r_q + 3'd1;
            j_q <= deg_q;
          end else begin
            j_q <= j_q - 3'd1;
          end
        end
        default: mode_q <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q        <= param_value_i;
      res_x_q    <= '0;
      res_y_q    <= '0;
      res_last_q <= 1'b1;
    end
    if (state_q == S_DEG_CAP) begin
      res_x_q    <= ctrl_rd_x_q;
      res_y_q    <= ctrl_rd_y_q;
      res_last_q <= (mode_q == bdb_pkg::MODE_EVAL) || ((i_q + 7'd1) == cc_q);
    end
    if (state_q == S_EV_CAP) begin
      res_x_q    <= work_rd_x_q;
      res_y_q    <= work_rd_y_q;
      res_last_q <= (mode_q == bdb_pkg::MODE_EVAL) || ((i_q + 7'd1) == sc_q);
    end
    if (state_q == S_TS_K1) start_q <= knot_rd_q;
    if (state_q == S_TS_K2) end_q   <= knot_rd_q;
    if (state_q == S_TS_DIVW && ar_rsp.done) t_q <= t_sum[CW-1:0];
    if (state_q == S_BL_K1) lower_q <= knot_rd_q;
    if (state_q == S_BL_K2) begin
      alpha_mag_q <= '0;
      alpha_neg_q <= n_s[AW-1];
    end
    if (state_q == S_BL_DIVW && ar_rsp.done) alpha_mag_q <= ar_res[BW-1:0];
    if (state_q == S_BL_W1) begin
      prev_x_q <= work_rd_x_q;
      prev_y_q <= work_rd_y_q;
    end
    if (state_q == S_BL_W2) begin
      negx_q <= dx_s[AW-1] ^ alpha_neg_q;
      negy_q <= dy_s[AW-1] ^ alpha_neg_q;
      dmy_q  <= dmy;
    end
    if (state_q == S_BL_MXW && ar_rsp.done) new_x_q <= blend_sat(prev_x_q, negx_q, ar_res);
    if (emit_go) begin
      out_x_q    <= res_x_q;
      out_y_q    <= res_y_q;
      out_last_q <= res_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = out_x_q;
  assign point_y_o    = out_y_q;
  assign last_point_o = out_last_q;

  a_arith_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ar_req.start |-> !ar_rsp.busy)
    else $error("arith unit started while busy");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ar_rsp.done |-> (state_q == S_TS_MULW || state_q == S_TS_DIVW ||
                     state_q == S_BL_DIVW || state_q == S_BL_MXW ||
                     state_q == S_BL_MYW))
    else $error("arith result arrived outside a wait step");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !out_ready_i) |=> state_q == S_EMIT)
    else $error("pending result overwritten");

  a_bisect_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BS_CMP) |-> (lo_q < hi_q && hi_q <= cc_q))
    else $error("span bisection bounds crossed");

  a_blend_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BL_K0) |-> (r_q >= 3'd1 && j_q >= r_q && j_q <= deg_q))
    else $error("blend index out of range");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the B-spline De Boor evaluator. Loads control
// point and knot stores, runs evaluate and tessellate requests over many
// register settings with random sender gaps and receiver stalls, and checks
// every curve point against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bdb_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam longint     Q_MAX      = 64'sd2147483647;
  localparam longint     Q_MIN      = -64'sd2147483648;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } curve_pt_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i        = '0;
  logic [6:0]         slot_i        = '0;
  logic signed [31:0] coord_x_i     = '0;
  logic signed [31:0] coord_y_i     = '0;
  logic signed [31:0] param_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic signed [31:0] point_x_o;
  logic signed [31:0] point_y_o;
  logic               last_point_o;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i   = '0;
  logic [6:0]         cfg_data_i    = '0;

  // predictor state
  int unsigned degree_q, ctrl_cnt_q, knot_cnt_q, samples_q;
  longint      ctrl_x_mem [CTRL_DEPTH];
  longint      ctrl_y_mem [CTRL_DEPTH];
  longint      knot_mem   [KNOT_DEPTH];
  curve_pt_t   pending_pts[$];

  int          err_cnt       = 0;
  int unsigned idle_cycles   = 0;
  int unsigned rx_hold       = 0;
  int unsigned rx_cycle      = 0;
  int unsigned rx_stall_pct  = 0;
  int unsigned burst_left    = 0;
  bit          tx_gaps       = 1'b1;

  bspline_de_boor_evaluator_top u_dut (.*);

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // fixed-point curve predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_q(longint v);
    return v > Q_MAX ? Q_MAX : (v < Q_MIN ? Q_MIN : v);
  endfunction

  function automatic longint knot_at(int unsigned i);
    return i < KNOT_DEPTH ? knot_mem[i] : 64'sd0;
  endfunction

  function automatic longint alpha_q(longint t, longint lo, longint up);
    longint w, n;
    longint unsigned nm, wm, q, r, a;
    w = up - lo;
    n = t - lo;
    if (w <= 0) return 0;
    nm = n < 0 ? -n : n;
    wm = w;
    q  = nm / wm;
    r  = nm % wm;
    if (q >= (64'd1 << (62 - FRAC_W))) begin
      a = 64'd1 << 62;
    end else begin
      a = q;
      for (int i = 0; i < FRAC_W; i++) begin
        r = r << 1;
        a = a << 1;
        if (r >= wm) begin
          r = r - wm;
          a = a | 64'd1;
        end
      end
    end
    return n < 0 ? -$signed(a) : $signed(a);
  endfunction

  function automatic longint blend_q(longint prev, longint cur, longint alpha);
    longint d;
    longint unsigned dm, am, tm;
    bit neg;
    d   = cur - prev;
    dm  = d < 0 ? -d : d;
    am  = alpha < 0 ? -alpha : alpha;
    neg = (d < 0) != (alpha < 0);
    if (dm == 0 || am == 0) return clamp_q(prev);
    if (am > 64'hFFFF_FFFF_FFFF_FFFF / dm) tm = 64'd1 << 60;
    else tm = (dm * am) >> FRAC_W;
    if (tm > (64'd1 << 60)) tm = 64'd1 << 60;
    return clamp_q(neg ? prev - $signed(tm) : prev + $signed(tm));
  endfunction

  function automatic int unsigned locate_span(longint t);
    int unsigned lo, hi, mid;
    lo = degree_q;
    hi = ctrl_cnt_q;
    if (t <= knot_at(degree_q)) return degree_q;
    if (t >= knot_at(ctrl_cnt_q)) return ctrl_cnt_q - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (t < knot_at(mid)) hi = mid;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic void de_boor_point(longint t, output longint px, output longint py);
    longint wx [DEG_MAX + 1];
    longint wy [DEG_MAX + 1];
    longint a;
    int unsigned p, sp, idx;
    p  = degree_q;
    sp = locate_span(t);
    for (int unsigned j = 0; j <= p; j++) begin
      idx   = j + sp - p;
      wx[j] = idx < CTRL_DEPTH ? ctrl_x_mem[idx] : 0;
      wy[j] = idx < CTRL_DEPTH ? ctrl_y_mem[idx] : 0;
    end
    for (int unsigned r = 1; r <= p; r++) begin
      for (int unsigned j = p; j >= r; j--) begin
        a     = alpha_q(t, knot_at(j + sp - p), knot_at(j + 1 + sp - r));
        wx[j] = blend_q(wx[j-1], wx[j], a);
        wy[j] = blend_q(wy[j-1], wy[j], a);
      end
    end
    px = wx[p];
    py = wy[p];
  endfunction

  function automatic void push_point(longint x, longint y, bit last);
    curve_pt_t pt;
    pt.x    = x[31:0];
    pt.y    = y[31:0];
    pt.last = last;
    pending_pts.push_back(pt);
  endfunction

  function automatic int curve_kind();
    if (ctrl_cnt_q == 0) return 0;
    if (degree_q < 1 || degree_q > DEG_MAX || ctrl_cnt_q <= degree_q ||
        knot_cnt_q < ctrl_cnt_q + degree_q + 1) return 1;
    return 2;
  endfunction

  function automatic void predict_points(mode_e mode, int unsigned slot,
                                         longint cx, longint cy, longint pv);
    longint x, y, s, e, t;
    int kind;
    if (mode == MODE_CTRL) begin
      if (slot < CTRL_DEPTH) begin
        ctrl_x_mem[slot] = cx;
        ctrl_y_mem[slot] = cy;
      end
      return;
    end
    if (mode == MODE_KNOT) begin
      if (slot < KNOT_DEPTH) knot_mem[slot] = pv;
      return;
    end
    kind = curve_kind();
    if (mode == MODE_EVAL) begin
      if (kind == 0) push_point(0, 0, 1'b1);
      else if (kind == 1) push_point(ctrl_x_mem[0], ctrl_y_mem[0], 1'b1);
      else begin
        de_boor_point(pv, x, y);
        push_point(x, y, 1'b1);
      end
      return;
    end
    if (kind == 1) begin
      for (int unsigned i = 0; i < ctrl_cnt_q; i++)
        push_point(ctrl_x_mem[i], ctrl_y_mem[i], i + 1 == ctrl_cnt_q);
    end else if (kind == 2) begin
      s = knot_at(degree_q);
      e = knot_at(ctrl_cnt_q);
      for (int unsigned i = 0; i < samples_q; i++) begin
        t = s + ((e - s) * longint'(i)) / longint'(samples_q - 1);
        de_boor_point(t, x, y);
        push_point(x, y, i + 1 == samples_q);
      end
    end
  endfunction

  function automatic void apply_register(cfg_idx_e idx, int unsigned v);
    case (idx)
      CFG_DEGREE:  degree_q   = v & 7;
      CFG_CONTROL: ctrl_cnt_q = v > CTRL_DEPTH ? CTRL_DEPTH : v;
      CFG_KNOTS:   knot_cnt_q = v > KNOT_DEPTH ? KNOT_DEPTH : v;
      default: begin
        samples_q = v < 2 ? 2 : (v > CTRL_DEPTH ? CTRL_DEPTH : v);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // sender, configuration and receiver
  // --------------------------------------------------------------------------
  task automatic send_item(mode_e mode, int unsigned slot, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] pv);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = tx_gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    slot_i        <= slot[6:0];
    coord_x_i     <= cx;
    coord_y_i     <= cy;
    param_value_i <= pv;
    do @(posedge clk_i); while (!in_ready_o);
    predict_points(mode, slot & 127, longint'($signed(cx)), longint'($signed(cy)),
                   longint'($signed(pv)));
  endtask

  task automatic drain_points();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_pts.size() != 0);
  endtask

  task automatic set_config(int unsigned deg, int unsigned cc, int unsigned kc,
                            int unsigned sc);
    int unsigned vals [4];
    cfg_idx_e idx;
    vals = '{deg, cc, kc, sc};
    drain_points();
    repeat (20) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i][6:0];
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_register(idx, vals[i] & 127);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 512 == 0) rx_stall_pct <= $urandom_range(0, 80);
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= rx_hold - 1;
    end else if (rx_cycle % 512 < 128) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= $urandom_range(0, 99) >= rx_stall_pct;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 40) $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    curve_pt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pts.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 40) $display("unexpected point %h %h", point_x_o, point_y_o);
      end else begin
        want = pending_pts.pop_front();
        if (point_x_o !== want.x) report_mismatch("point_x", point_x_o, want.x);
        if (point_y_o !== want.y) report_mismatch("point_y", point_y_o, want.y);
        if (last_point_o !== want.last)
          report_mismatch("last_point", 32'(last_point_o), 32'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 9) < 3) return $urandom;
    return $signed($urandom) >>> $urandom_range(6, 12);
  endfunction

  task automatic load_ordered_knots(int unsigned kc);
    longint v;
    v = longint'($signed($urandom)) >>> 12;
    for (int unsigned i = 0; i < kc && i < KNOT_DEPTH; i++) begin
      if (i > 0 && $urandom_range(0, 4) != 0) v = v + $urandom_range(1, 3 << FRAC_W);
      send_item(MODE_KNOT, i, rand_coord(), rand_coord(), v[31:0]);
    end
  endtask

  function automatic logic [31:0] pick_param();
    longint s, e, w, t;
    if ($urandom_range(0, 99) < 15) return $urandom;
    s = knot_at(degree_q);
    e = knot_at(ctrl_cnt_q < KNOT_DEPTH ? ctrl_cnt_q : 0);
    w = e - s;
    if (w <= 0 || w > 64'sd1000000000) w = 64'sd65536;
    t = clamp_q(s - w / 8 + longint'($urandom) % (w * 5 / 4 + 1));
    return t[31:0];
  endfunction

  task automatic send_random_item();
    int unsigned r, slot;
    longint lo, hi, v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      slot = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 63);
      send_item(MODE_CTRL, slot, rand_coord(), rand_coord(), $urandom);
    end else if (r < 50) begin
      if (knot_cnt_q >= 3 && $urandom_range(0, 9) < 7) begin
        slot = $urandom_range(1, knot_cnt_q - 2);
        lo   = knot_mem[slot-1];
        hi   = knot_mem[slot+1];
        v    = hi >= lo ? lo + longint'($urandom) % (hi - lo + 1) : lo;
        send_item(MODE_KNOT, slot, $urandom, $urandom, v[31:0]);
      end else begin
        send_item(MODE_KNOT, $urandom_range(0, 127), $urandom, $urandom, $urandom);
      end
    end else if (r < 94) begin
      send_item(MODE_EVAL, $urandom_range(0, 127), $urandom, $urandom, pick_param());
    end else begin
      send_item(MODE_TESS, $urandom_range(0, 127), $urandom, $urandom, $urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_load_stores();
    for (int unsigned i = 0; i < CTRL_DEPTH; i++)
      send_item(MODE_CTRL, i, rand_coord(), rand_coord(), $urandom);
    for (int unsigned i = 0; i < KNOT_DEPTH; i++)
      send_item(MODE_KNOT, i, $urandom, $urandom, 32'(i << FRAC_W));
  endtask

  task automatic test_empty_curve();
    set_config(3, 0, 0, 16);
    send_item(MODE_EVAL, 0, '0, '0, 32'h0001_8000);
    send_item(MODE_TESS, 0, '0, '0, '0);
    send_item(MODE_CTRL, 64, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_item(MODE_CTRL, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_item(MODE_KNOT, 72, '0, '0, 32'h8000_0000);
    send_item(MODE_KNOT, 127, '0, '0, 32'hFFFF_FFFF);
  endtask

  task automatic test_degenerate_curves();
    set_config(0, 5, 127, 0);
    send_item(MODE_EVAL, 0, '0, '0, '0);
    send_item(MODE_TESS, 0, '0, '0, '0);
    set_config(4, 4, 20, 1);
    send_item(MODE_EVAL, 0, '0, '0, 32'h0002_0000);
    set_config(3, 8, 11, 2);
    send_item(MODE_TESS, 0, '0, '0, '0);
    set_config(7, 127, 127, 127);
    send_item(MODE_EVAL, 0, '0, '0, 32'h0010_0000);
  endtask

  task automatic test_extremes();
    set_config(3, 6, 10, 3);
    send_item(MODE_CTRL, 0, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_item(MODE_CTRL, 5, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    // repeated knots give zero-width intervals
    send_item(MODE_KNOT, 4, '0, '0, 32'h0000_0000);
    send_item(MODE_KNOT, 5, '0, '0, 32'h0000_0000);
    send_item(MODE_EVAL, 0, '0, '0, 32'h8000_0000);
    send_item(MODE_EVAL, 0, '0, '0, 32'h7FFF_FFFF);
    send_item(MODE_EVAL, 0, '0, '0, 32'h0005_8000);
    send_item(MODE_TESS, 0, '0, '0, '0);
    // unordered knots
    send_item(MODE_KNOT, 4, '0, '0, 32'h7FFF_0000);
    send_item(MODE_EVAL, 0, '0, '0, 32'h0004_0000);
  endtask

  task automatic test_backpressure();
    set_config(2, 10, 13, 3);
    load_ordered_knots(13);
    tx_gaps = 1'b0;
    rx_hold = 3000;
    repeat (10) send_item(MODE_EVAL, 0, '0, '0, pick_param());
    send_item(MODE_TESS, 0, '0, '0, '0);
    tx_gaps = 1'b1;
    drain_points();
  endtask

  task automatic test_random_traffic();
    int unsigned deg_tab [10] = '{3, 1, 7, 2, 5, 3, 7, 1, 4, 6};
    int unsigned cc_tab  [10] = '{8, 2, 64, 64, 20, 12, 9, 40, 5, 30};
    int unsigned sc_tab  [10] = '{5, 64, 2, 3, 4, 6, 3, 8, 127, 2};
    int unsigned deg, cc, kc, sc;
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 10) begin
        deg = deg_tab[ph];
        cc  = cc_tab[ph];
        sc  = sc_tab[ph];
        kc  = cc + deg + 1;
      end else begin
        deg = $urandom_range(0, 7);
        cc  = $urandom_range(0, 127);
        kc  = $urandom_range(0, 127);
        sc  = $urandom_range(0, 10);
      end
      tx_gaps = ph % 4 != 3;
      set_config(deg, cc, kc, sc);
      load_ordered_knots(kc);
      repeat (25) send_random_item();
      if (ph == 6) drain_points();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    degree_q   = 3;
    ctrl_cnt_q = 0;
    knot_cnt_q = 0;
    samples_q  = 16;
    test_load_stores();
    test_empty_curve();
    test_degenerate_curves();
    test_extremes();
    test_backpressure();
    test_random_traffic();
    drain_points();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && pending_pts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bdb_pkg.sv
hdl/bdb_arith.sv
hdl/bspline_de_boor_evaluator_top.sv
tb/tb_top.sv
